// ----- sv/ssc_pkg.sv -----
package ssc_pkg;

	// result kinds
	localparam logic [2:0] KIND_FIRST   = 3'd0;
	localparam logic [2:0] KIND_CONSEC  = 3'd1;
	localparam logic [2:0] KIND_BITFAIL = 3'd2;
	localparam logic [2:0] KIND_GAP     = 3'd3;
	localparam logic [2:0] KIND_NOCOUNT = 3'd4;

	// register word index on the configuration port
	localparam logic REG_EXP_STEP = 1'b0;

	// beam mode that is processed
	localparam logic [7:0] MODE_BEAM = 8'd1;

	// wrap detection constants
	localparam int SPILL_RAW_BITS  = 15;
	localparam int COUNT_RAW_BITS  = 16;
	localparam int SPILL_SMALL     = 32'h0002;
	localparam int SPILL_BOUNDARY  = 32'h7ffd;
	localparam int COUNT_SMALL     = 32'h0014;
	localparam int COUNT_BOUNDARY  = 32'hfffd;

	localparam logic [15:0] EXP_STEP_RESET = 16'd7;
	localparam logic [30:0] MIN_SPILL_RESET = 31'd32768;

	// width of the internal difference arithmetic
	localparam int AW = 34;

	typedef logic signed [AW-1:0] diff_t;

	// saturate a wide signed difference to 32 bits
	function automatic logic [31:0] sat_s32(input diff_t v);
		logic [31:0] r;
		if (v > diff_t'(64'sh7fffffff)) begin
			r = 32'h7fffffff;
		end else if (v < -diff_t'(64'sh80000000)) begin
			r = 32'h80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// saturating increment of a 32-bit total
	function automatic logic [31:0] inc_sat32(input logic [31:0] v);
		return (&v) ? v : v + 32'd1;
	endfunction

endpackage

// ----- sv/spill_sequence_checker_unit.sv -----
// channel   | dir | payload
// s_axis    | in  | tdata: raw_spill, spill_counter; tuser: beam_mode
// m_axis    | out | tdata: result fields; tuser: result_kind; tlast: last_of_run
// apb       | in  | expected_count_step at byte address 0
//
// one input register stage, then one result register: an accepted item is held in the
// input register and then in the result register before its result is on the port
// a new item is taken every cycle while the input does not stall; a single-bit failure
// holds the result register for two output beats
// records whose beam mode is not 1 are dropped at the input register
// reset (arst_n low) clears all counters, previous values and the handshake state
// the input stalls while the input register is full and the result register holds a beat
// that is not taken, or holds the first beat of a bit failure
module spill_sequence_checker_unit
	import ssc_pkg::*;
#(
	parameter int SPILL_WRAP_BITS = 16,
	parameter int COUNT_WRAP_BITS = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // raw_spill[14:0], spill_counter[31:16]
	input  logic [7:0]   s_tuser,   // beam_mode[7:0]
	// result items
	output logic         m_tvalid,
	input  logic         m_tready,
	// corrected_spill[30:0], spill_step[62:31], extended_count[93:63],
	// count_step[125:94], count_gap[126], total_spills[158:127], total_gaps[190:159],
	// total_bit_failures[222:191], lowest_spill[253:223], highest_spill[285:254],
	// zero fill [287:286]
	output logic [287:0] m_tdata,
	output logic [2:0]   m_tuser,   // result_kind[2:0]
	output logic         m_tlast,   // last_of_run
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int SW = SPILL_RAW_BITS + SPILL_WRAP_BITS;
	localparam int CW = COUNT_RAW_BITS + COUNT_WRAP_BITS;

	// configuration register
	logic [15:0] exp_step_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EXP_STEP) ? {16'd0, exp_step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_step_q <= EXP_STEP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXP_STEP) begin
			exp_step_q <= pwdata[15:0];
		end
	end

	// input register stage
	logic        valid_s1;
	logic [14:0] spill_raw_s1;
	logic [15:0] count_raw_s1;
	logic        adv;
	logic        in_acc;
	logic        out_take;

	logic        out_valid_s2;
	logic        out_last_s2;

	assign adv      = valid_s1 && (!out_valid_s2 || (m_tready && out_last_s2));
	assign s_tready = !valid_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;
	assign out_take = out_valid_s2 && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= (s_tuser == MODE_BEAM);
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			spill_raw_s1 <= s_tdata[14:0];
			count_raw_s1 <= s_tdata[31:16];
		end
	end

	// checker state
	logic signed [31:0]         prev_spill_q, pprev_spill_q;
	logic signed [31:0]         prev_count_q, pprev_count_q;
	logic [SPILL_WRAP_BITS-1:0] spill_wraps_q;
	logic [COUNT_WRAP_BITS-1:0] count_wraps_q;
	logic [31:0]                spill_total_q, gap_total_q, bitfail_total_q;
	logic [30:0]                min_spill_q;
	logic signed [31:0]         max_spill_q;

	// previous values widened for the difference arithmetic
	diff_t p0s, p1s, p0c, p1c;
	assign p0s = diff_t'(prev_spill_q);
	assign p1s = diff_t'(pprev_spill_q);
	assign p0c = diff_t'(prev_count_q);
	assign p1c = diff_t'(pprev_count_q);

	// wrap detection against the two previous unwrapped values
	diff_t spill_base, count_base, spill_x, count_x;
	logic  spill_wrap, count_wrap;
	logic [SPILL_WRAP_BITS-1:0] spill_wraps_n;
	logic [COUNT_WRAP_BITS-1:0] count_wraps_n;

	always_comb begin
		spill_base = diff_t'({spill_wraps_q, {SPILL_RAW_BITS{1'b0}}});
		count_base = diff_t'({count_wraps_q, {COUNT_RAW_BITS{1'b0}}});
		spill_x    = diff_t'(spill_raw_s1) + spill_base;
		count_x    = diff_t'(count_raw_s1) + count_base;
		spill_wrap = (diff_t'(spill_raw_s1) < diff_t'(SPILL_SMALL))
			&& (spill_x < p0s || spill_x < p1s)
			&& (p0s > diff_t'(SPILL_BOUNDARY) + spill_base
				|| p1s > diff_t'(SPILL_BOUNDARY) + spill_base);
		count_wrap = (diff_t'(count_raw_s1) < diff_t'(COUNT_SMALL))
			&& (count_x < p0c || count_x < p1c)
			&& (p0c > diff_t'(COUNT_BOUNDARY) + count_base
				|| p1c > diff_t'(COUNT_BOUNDARY) + count_base);
		spill_wraps_n = (spill_wrap && !(&spill_wraps_q))
			? spill_wraps_q + SPILL_WRAP_BITS'(1) : spill_wraps_q;
		count_wraps_n = (count_wrap && !(&count_wraps_q))
			? count_wraps_q + COUNT_WRAP_BITS'(1) : count_wraps_q;
	end

	// unwrapped values and differences
	logic [SW-1:0] spill_ext;
	logic [CW-1:0] count_ext;
	diff_t         d0, d1, dd, cstep;
	logic          gap_flag;
	logic          bitfail;

	always_comb begin
		spill_ext = {spill_wraps_n, spill_raw_s1};
		count_ext = {count_wraps_n, count_raw_s1};
		d0        = diff_t'(spill_ext) - p0s;
		d1        = p0s - p1s;
		dd        = d0 - d1;
		cstep     = diff_t'(count_ext) - p0c;
		gap_flag  = (prev_count_q != -32'sd1) && (cstep != diff_t'(exp_step_q));
		bitfail   = 1'b0;
		for (int k = 0; k < 15; k++) begin
			if (d0 == (diff_t'(1) << k) + diff_t'(1) && dd == (diff_t'(1) << (k + 1))) begin
				bitfail = 1'b1;
			end
		end
	end

	// classification and totals
	logic [2:0]  kind;
	logic [31:0] spill_total_n, gap_total_n, bitfail_total_n;
	logic [30:0] min_spill_n;
	logic signed [31:0] max_spill_n;

	always_comb begin
		spill_total_n   = spill_total_q;
		gap_total_n     = gap_total_q;
		bitfail_total_n = bitfail_total_q;
		if (prev_spill_q == -32'sd1) begin
			kind          = KIND_FIRST;
			spill_total_n = inc_sat32(spill_total_q);
		end else if (d0 == diff_t'(1)) begin
			kind          = KIND_CONSEC;
			spill_total_n = inc_sat32(spill_total_q);
		end else if (bitfail) begin
			kind            = KIND_BITFAIL;
			spill_total_n   = inc_sat32(spill_total_q);
			bitfail_total_n = inc_sat32(bitfail_total_q);
		end else if (d0 > diff_t'(1)) begin
			kind          = KIND_GAP;
			spill_total_n = inc_sat32(spill_total_q);
			gap_total_n   = inc_sat32(gap_total_q);
		end else begin
			kind = KIND_NOCOUNT;
		end
		min_spill_n = (31'(spill_ext) < min_spill_q) ? 31'(spill_ext) : min_spill_q;
		max_spill_n = (32'sd0 + $signed({1'b0, 31'(spill_ext)}) > max_spill_q)
			? $signed({1'b0, 31'(spill_ext)}) : max_spill_q;
	end

	// state update when an item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_spill_q    <= -32'sd1;
			pprev_spill_q   <= -32'sd1;
			prev_count_q    <= -32'sd1;
			pprev_count_q   <= -32'sd1;
			spill_wraps_q   <= '0;
			count_wraps_q   <= '0;
			spill_total_q   <= '0;
			gap_total_q     <= '0;
			bitfail_total_q <= '0;
			min_spill_q     <= MIN_SPILL_RESET;
			max_spill_q     <= -32'sd1;
		end else if (adv) begin
			pprev_spill_q   <= prev_spill_q;
			prev_spill_q    <= $signed({1'b0, 31'(spill_ext)});
			pprev_count_q   <= prev_count_q;
			prev_count_q    <= $signed({1'b0, 31'(count_ext)});
			spill_wraps_q   <= spill_wraps_n;
			count_wraps_q   <= count_wraps_n;
			spill_total_q   <= spill_total_n;
			gap_total_q     <= gap_total_n;
			bitfail_total_q <= bitfail_total_n;
			min_spill_q     <= min_spill_n;
			max_spill_q     <= max_spill_n;
		end
	end

	// result register
	logic [30:0] cs_s2, spill_s2, count_s2, min_s2;
	logic [31:0] d0_s2, cstep_s2, tot_s2, gaps_s2, bitf_s2, max_s2;
	logic [2:0]  kind_s2;
	logic        gap_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
			out_last_s2  <= 1'b1;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
			out_last_s2  <= (kind != KIND_BITFAIL);
		end else if (out_take && out_last_s2) begin
			out_valid_s2 <= 1'b0;
		end else if (out_take) begin
			out_last_s2 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_s2    <= (kind == KIND_BITFAIL) ? 31'(spill_ext) - 31'd1 : 31'(spill_ext);
			spill_s2 <= 31'(spill_ext);
			count_s2 <= 31'(count_ext);
			d0_s2    <= sat_s32(d0);
			cstep_s2 <= sat_s32(cstep);
			kind_s2  <= kind;
			gap_s2   <= gap_flag;
			tot_s2   <= spill_total_n;
			gaps_s2  <= gap_total_n;
			bitf_s2  <= bitfail_total_n;
			min_s2   <= min_spill_n;
			max_s2   <= max_spill_n;
		end else if (out_take && !out_last_s2) begin
			// second beat of a bit failure carries the spill itself
			cs_s2 <= spill_s2;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tlast  = out_last_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {2'b00, max_s2, min_s2, bitf_s2, gaps_s2, tot_s2, gap_s2,
		cstep_s2, count_s2, d0_s2, cs_s2};

`ifndef SYNTHESIS
	// only a bit failure gives a beat that is not the last
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_BITFAIL) |-> m_tlast)
		else $error("non-last beat on a result that is not a bit failure");

	// the first beat of a bit failure is followed by its second beat
	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && m_tlast && m_tuser == KIND_BITFAIL))
		else $error("bit failure second beat missing");

	// the spill total never goes down
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		spill_total_q >= $past(spill_total_q))
		else $error("spill total decreased");
`endif

endmodule
